// ===== rtl/msag_pkg.sv =====
// ----------------------------------------------------------------------------
// msag_pkg
// Shared types and constants for the ModR/M and SIB address generator:
// the address size code and the decoded item passed from front to back.
// ----------------------------------------------------------------------------
package msag_pkg;

   // Default number of mirrored general registers
   localparam int GPR_COUNT = 16;

   // Entries in the front-to-back queue (power of two)
   localparam int QUEUE_DEPTH = 4;

   // Item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_ADDR  = 1'b1;

   // Address size after folding the reserved code into 64-bit
   typedef enum logic [1:0] {
      SIZE_16 = 2'd0,
      SIZE_32 = 2'd1,
      SIZE_64 = 2'd2
   } size_type;

   // Decoded item: register numbers to read, addend and finished flags.
   // For a write item, base_num carries the register number and addend
   // carries the value to load.
   typedef struct packed {
      logic        is_write;
      logic [3:0]  base_num;
      logic        base_en;
      logic [3:0]  index_num;
      logic        index_en;
      logic [1:0]  scale;
      size_type    size;
      logic [63:0] addend;
      logic        is_register;
      logic [3:0]  reg_field;
      logic [3:0]  rm_field;
      logic        sib_present;
      logic [2:0]  disp_bytes;
      logic        rip_relative;
   } msag_entry_type;

endpackage

// ===== rtl/msag_front.sv =====
// ----------------------------------------------------------------------------
// msag_front
// Accepts items and decodes the ModR/M / SIB addressing form into a queue
// entry: which registers to read, the scale, and a single constant addend.
// ----------------------------------------------------------------------------
module msag_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [3:0]               req_write_index,
   input  logic [63:0]              req_write_value,
   input  logic [7:0]               req_modrm_byte,
   input  logic [7:0]               req_sib_byte,
   input  logic signed [31:0]       req_displacement,
   input  logic                     req_rex_r,
   input  logic                     req_rex_b,
   input  logic                     req_rex_x,
   input  logic [1:0]               req_addr_size,
   input  logic [63:0]              req_next_ip,
   input  logic                     q_full,
   output logic                     q_push,
   output msag_pkg::msag_entry_type q_entry
);
   import msag_pkg::*;

   // ModR/M encodings
   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISPW   = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;
   localparam logic [2:0] RM_SIB      = 3'd4;
   localparam logic [2:0] RM_DISP32   = 3'd5;
   localparam logic [2:0] RM16_DIRECT = 3'd6;
   localparam logic [2:0] BASE_DISP32 = 3'd5;
   localparam logic [3:0] NO_INDEX    = 4'd4;

   // Displacement lengths
   localparam logic [2:0] DISP_NONE = 3'd0;
   localparam logic [2:0] DISP_1    = 3'd1;
   localparam logic [2:0] DISP_2    = 3'd2;
   localparam logic [2:0] DISP_4    = 3'd4;

   // 16-bit base register by rm: BX BX BP BP SI DI BP BX
   function automatic logic [3:0] base16(input logic [2:0] rm);
      case (rm)
         3'd0, 3'd1, 3'd7: return 4'd3;
         3'd2, 3'd3, 3'd6: return 4'd5;
         3'd4:             return 4'd6;
         default:          return 4'd7;
      endcase
   endfunction

   // 16-bit index register by rm: SI DI SI DI, none for rm 4..7
   function automatic logic [3:0] index16(input logic [2:0] rm);
      return rm[0] ? 4'd7 : 4'd6;
   endfunction

   logic [1:0]  mod_f;
   logic [2:0]  reg_f;
   logic [2:0]  rm_f;
   logic [63:0] sx8;
   logic [63:0] sx32;
   logic [63:0] zx16;
   logic [63:0] disp_w;
   logic [2:0]  disp_w_bytes;
   logic [3:0]  sib_index;
   size_type    size;
   msag_entry_type e;

   assign mod_f = req_modrm_byte[7:6];
   assign reg_f = req_modrm_byte[5:3];
   assign rm_f  = req_modrm_byte[2:0];
   assign sx8   = {{56{req_displacement[7]}}, req_displacement[7:0]};
   assign sx32  = {{32{req_displacement[31]}}, req_displacement[31:0]};
   assign zx16  = {48'd0, req_displacement[15:0]};
   assign sib_index = {req_rex_x, req_sib_byte[5:3]};

   // Handshake: take an item whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = e;

   // Fold the reserved size code into 64-bit
   always_comb begin
      case (req_addr_size)
         2'd0:    size = SIZE_16;
         2'd1:    size = SIZE_32;
         default: size = SIZE_64;
      endcase
   end

   // Displacement carried by mod 1 / mod 2 for this size
   always_comb begin
      case (mod_f)
         MOD_DISP8: begin
            disp_w       = sx8;
            disp_w_bytes = DISP_1;
         end
         MOD_DISPW: begin
            disp_w       = (size == SIZE_16) ? zx16 : sx32;
            disp_w_bytes = (size == SIZE_16) ? DISP_2 : DISP_4;
         end
         default: begin
            disp_w       = 64'd0;
            disp_w_bytes = DISP_NONE;
         end
      endcase
   end

   // Decode the addressing form
   always_comb begin
      e = '0;
      e.size = size;
      if (req_op == OP_WRITE) begin
         e.is_write = 1'b1;
         e.base_num = req_write_index;
         e.addend   = req_write_value;
      end else begin
         e.reg_field = {req_rex_r, reg_f};
         e.rm_field  = {req_rex_b, rm_f};
         if (mod_f == MOD_REG) begin
            e.is_register = 1'b1;
         end else if (size == SIZE_16) begin
            if (mod_f == MOD_NO_DISP && rm_f == RM16_DIRECT) begin
               e.addend     = zx16;
               e.disp_bytes = DISP_2;
            end else begin
               e.base_en    = 1'b1;
               e.base_num   = base16(rm_f);
               e.index_en   = !rm_f[2];
               e.index_num  = index16(rm_f);
               e.addend     = disp_w;
               e.disp_bytes = disp_w_bytes;
            end
         end else if (rm_f == RM_SIB) begin
            e.sib_present = 1'b1;
            e.scale       = req_sib_byte[7:6];
            e.index_num   = sib_index;
            e.index_en    = (sib_index != NO_INDEX);
            e.base_num    = {req_rex_b, req_sib_byte[2:0]};
            if (mod_f == MOD_NO_DISP && req_sib_byte[2:0] == BASE_DISP32) begin
               e.addend     = sx32;
               e.disp_bytes = DISP_4;
            end else begin
               e.base_en    = 1'b1;
               e.addend     = disp_w;
               e.disp_bytes = disp_w_bytes;
            end
         end else if (mod_f == MOD_NO_DISP && rm_f == RM_DISP32) begin
            e.disp_bytes = DISP_4;
            if (size == SIZE_64) begin
               e.rip_relative = 1'b1;
               e.addend       = req_next_ip + sx32;
            end else begin
               e.addend = sx32;
            end
         end else begin
            e.base_en    = 1'b1;
            e.base_num   = {req_rex_b, rm_f};
            e.addend     = disp_w;
            e.disp_bytes = disp_w_bytes;
         end
      end
   end

endmodule

// ===== rtl/msag_queue.sv =====
// ----------------------------------------------------------------------------
// msag_queue
// Small FIFO of decoded items between the front and the back, so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module msag_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  msag_pkg::msag_entry_type push_entry,
   output logic                     full,
   output logic                     head_valid,
   output msag_pkg::msag_entry_type head_entry,
   input  logic                     pop
);
   import msag_pkg::*;

   localparam int QA = $clog2(QUEUE_DEPTH);

   msag_entry_type entries_ff [QUEUE_DEPTH];
   logic [QA-1:0]  wr_ptr_ff;
   logic [QA-1:0]  wr_ptr_in;
   logic [QA-1:0]  rd_ptr_ff;
   logic [QA-1:0]  rd_ptr_in;
   logic [QA:0]    count_ff;
   logic [QA:0]    count_in;

   assign full       = (count_ff == (QA+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/msag_back.sv =====
// ----------------------------------------------------------------------------
// msag_back
// Executes decoded items in order: writes go into the register mirror,
// address items read base and index from it, then add, wrap and register
// the result.
// ----------------------------------------------------------------------------
module msag_back #(
   parameter int NUM_GPRS = msag_pkg::GPR_COUNT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  msag_pkg::msag_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_eff_addr,
   output logic                     rsp_is_register,
   output logic [3:0]               rsp_reg_field,
   output logic [3:0]               rsp_rm_field,
   output logic                     rsp_sib_present,
   output logic [2:0]               rsp_disp_bytes,
   output logic                     rsp_rip_relative
);
   import msag_pkg::*;

   localparam int AW = $clog2(NUM_GPRS);

   function automatic logic [63:0] size_mask(input size_type s);
      case (s)
         SIZE_16: return 64'h0000_0000_0000_FFFF;
         SIZE_32: return 64'h0000_0000_FFFF_FFFF;
         default: return 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
   endfunction

   function automatic logic gpr_exists(input logic [3:0] num);
      return 32'(num) < NUM_GPRS;
   endfunction

   // Register mirror; an entry never written reads as zero
   logic [63:0]         gpr_mem [NUM_GPRS];
   logic [NUM_GPRS-1:0] gpr_valid_ff;

   // Read stage
   logic           s1_valid_ff;
   msag_entry_type s1_entry_ff;
   logic [63:0]    base_rd_ff;
   logic [63:0]    index_rd_ff;
   logic           base_ok_ff;
   logic           index_ok_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [63:0] rsp_eff_addr_ff;
   logic        rsp_is_register_ff;
   logic [3:0]  rsp_reg_field_ff;
   logic [3:0]  rsp_rm_field_ff;
   logic        rsp_sib_present_ff;
   logic [2:0]  rsp_disp_bytes_ff;
   logic        rsp_rip_relative_ff;

   logic        out_free;
   logic        s1_adv;
   logic        gpr_write;
   logic        base_ok_in;
   logic        index_ok_in;
   logic [63:0] vmask;
   logic [63:0] base_val;
   logic [63:0] index_val;
   logic [63:0] index_scaled;
   logic [63:0] sum;
   logic [63:0] eff_addr_in;

   // Flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || out_free;
   assign q_pop     = q_valid && s1_adv;
   assign gpr_write = q_pop && q_entry.is_write && gpr_exists(q_entry.base_num);

   assign base_ok_in  = q_entry.base_en && gpr_exists(q_entry.base_num)
                        && gpr_valid_ff[q_entry.base_num[AW-1:0]];
   assign index_ok_in = q_entry.index_en && gpr_exists(q_entry.index_num)
                        && gpr_valid_ff[q_entry.index_num[AW-1:0]];

   // Mirror write port and two registered read ports
   always_ff @(posedge clock) begin
      if (gpr_write) begin
         gpr_mem[q_entry.base_num[AW-1:0]] <= q_entry.addend;
      end
      if (q_pop) begin
         base_rd_ff  <= gpr_mem[q_entry.base_num[AW-1:0]];
         index_rd_ff <= gpr_mem[q_entry.index_num[AW-1:0]];
         base_ok_ff  <= base_ok_in;
         index_ok_ff <= index_ok_in;
         s1_entry_ff <= q_entry;
      end
   end

   // Valid bits and read stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (gpr_write) begin
            gpr_valid_ff[q_entry.base_num[AW-1:0]] <= 1'b1;
         end
         if (s1_adv) begin
            s1_valid_ff <= q_pop;
         end
      end
   end

   // Address sum, wrapped to the address size
   always_comb begin
      vmask        = size_mask(s1_entry_ff.size);
      base_val     = (base_ok_ff ? base_rd_ff : 64'd0) & vmask;
      index_val    = (index_ok_ff ? index_rd_ff : 64'd0) & vmask;
      index_scaled = index_val << s1_entry_ff.scale;
      sum          = base_val + index_scaled + s1_entry_ff.addend;
      eff_addr_in  = s1_entry_ff.is_write ? 64'd0 : (sum & vmask);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_eff_addr_ff     <= eff_addr_in;
         rsp_is_register_ff  <= s1_entry_ff.is_register;
         rsp_reg_field_ff    <= s1_entry_ff.reg_field;
         rsp_rm_field_ff     <= s1_entry_ff.rm_field;
         rsp_sib_present_ff  <= s1_entry_ff.sib_present;
         rsp_disp_bytes_ff   <= s1_entry_ff.disp_bytes;
         rsp_rip_relative_ff <= s1_entry_ff.rip_relative;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_eff_addr     = rsp_eff_addr_ff;
   assign rsp_is_register  = rsp_is_register_ff;
   assign rsp_reg_field    = rsp_reg_field_ff;
   assign rsp_rm_field     = rsp_rm_field_ff;
   assign rsp_sib_present  = rsp_sib_present_ff;
   assign rsp_disp_bytes   = rsp_disp_bytes_ff;
   assign rsp_rip_relative = rsp_rip_relative_ff;

endmodule

// ===== rtl/modrm_sib_address_generator.sv =====
// An accepted item reaches the output via the queue, the read stage and the output register.
// Throughput: one item per cycle unless the output stalls; a write item followed by a reader
//   of that register flows at full rate, as both pass the mirror in order at the queue head.
// The queue holds 4 items, so the input takes items while the output stalls, until it is full.
// Reset: clears queue, pipeline valids and the mirror's valid bits; every register reads zero.
// ----------------------------------------------------------------------------
// modrm_sib_address_generator
// x86 ModR/M and SIB effective-address generator with a mirror of the
// general registers: decode front, item queue, register read and add back.
// ----------------------------------------------------------------------------
module modrm_sib_address_generator #(
   parameter int NUM_GPRS = msag_pkg::GPR_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [3:0]         req_write_index,
   input  logic [63:0]        req_write_value,
   input  logic [7:0]         req_modrm_byte,
   input  logic [7:0]         req_sib_byte,
   input  logic signed [31:0] req_displacement,
   input  logic               req_rex_r,
   input  logic               req_rex_b,
   input  logic               req_rex_x,
   input  logic [1:0]         req_addr_size,
   input  logic [63:0]        req_next_ip,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_eff_addr,
   output logic               rsp_is_register,
   output logic [3:0]         rsp_reg_field,
   output logic [3:0]         rsp_rm_field,
   output logic               rsp_sib_present,
   output logic [2:0]         rsp_disp_bytes,
   output logic               rsp_rip_relative
);
   import msag_pkg::*;

   logic           q_full;
   logic           q_push;
   msag_entry_type q_push_entry;
   logic           q_head_valid;
   msag_entry_type q_head_entry;
   logic           q_pop;

   // Decode front
   msag_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_write_index  (req_write_index),
      .req_write_value  (req_write_value),
      .req_modrm_byte   (req_modrm_byte),
      .req_sib_byte     (req_sib_byte),
      .req_displacement (req_displacement),
      .req_rex_r        (req_rex_r),
      .req_rex_b        (req_rex_b),
      .req_rex_x        (req_rex_x),
      .req_addr_size    (req_addr_size),
      .req_next_ip      (req_next_ip),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_push_entry)
   );

   // Item queue
   msag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop)
   );

   // Register mirror and address back end
   msag_back #(
      .NUM_GPRS (NUM_GPRS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_head_valid),
      .q_entry          (q_head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_eff_addr     (rsp_eff_addr),
      .rsp_is_register  (rsp_is_register),
      .rsp_reg_field    (rsp_reg_field),
      .rsp_rm_field     (rsp_rm_field),
      .rsp_sib_present  (rsp_sib_present),
      .rsp_disp_bytes   (rsp_disp_bytes),
      .rsp_rip_relative (rsp_rip_relative)
   );

endmodule
